### rtl/core/resol_pkg.sv
// package for the ring entry store with offset lookup
// holds field widths, operation codes, parameter defaults and the item types
// no dependencies
package resol_pkg;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 20;
    localparam int BYTE_W   = 16;

    localparam int DEF_DEPTH       = 16;
    localparam int DEF_SIZE_BITS   = 16;
    localparam int DEF_HANDLE_BITS = 32;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [HANDLE_W-1:0] entry_handle;
        logic [SIZE_W-1:0]   entry_bytes;
        logic [OFFSET_W-1:0] seek_offset;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] hit_handle;
        logic [SIZE_W-1:0]   hit_size;
        logic [BYTE_W-1:0]   byte_within;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
    } out_item_t;

endpackage

### rtl/core/resol_if.sv
// valid/ready channel interfaces for the ring entry store
// depends on resol_pkg for the item types
interface resol_in_if;
    import resol_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface resol_out_if;
    import resol_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/resol_ram.sv
// entry memory: one write port, one read port with registered read data
// depends on resol_pkg for parameter defaults
module resol_ram #(
    parameter int DEPTH = resol_pkg::DEF_DEPTH,
    parameter int WIDTH = resol_pkg::DEF_HANDLE_BITS + resol_pkg::DEF_SIZE_BITS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/ring_entry_store_offset_lookup.sv
// top level of the ring entry store with byte offset lookup
// depends on resol_pkg, resol_if and resol_ram
//
// channel  dir  payload                                          item
// req      in   operation, entry_handle, entry_bytes, seek_offset  add or find
// rsp      out  found, hit_*, byte_within, evicted_*             one per req item
//
// add: ST_ADD then ST_EMIT (write and old read share one ram access)
// find: walks from the oldest entry until a hit, one stored entry read and summed per cycle
// req is taken only while the sequencer is idle; a waiting result does not block it
// a result that cannot leave holds the sequencer until rsp takes the pending one
// reset (rst_n, async) empties the ring; ram contents need no clearing
module ring_entry_store_offset_lookup #(
    parameter int DEPTH       = resol_pkg::DEF_DEPTH,
    parameter int SIZE_BITS   = resol_pkg::DEF_SIZE_BITS,
    parameter int HANDLE_BITS = resol_pkg::DEF_HANDLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    resol_in_if.sink    req,
    resol_out_if.source rsp
);
    import resol_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = SIZE_BITS + CNT_W;
    localparam int CMP_W   = (TOTAL_W > OFFSET_W) ? TOTAL_W : OFFSET_W;
    localparam int WORD_W  = HANDLE_BITS + SIZE_BITS;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       write_slot_reg, write_slot_next;
    logic [IDX_W-1:0]       oldest_slot_reg, oldest_slot_next;
    logic                   ring_full_reg, ring_full_next;
    logic [IDX_W-1:0]       walk_slot_reg, walk_slot_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   op_reg, op_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [CNT_W-1:0]       issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   flag_reg, flag_next;
    out_item_t              out_data_reg, out_data_next;

    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    logic [HANDLE_BITS-1:0] rd_handle;
    logic [SIZE_BITS-1:0]   rd_size;
    logic [TOTAL_W-1:0]     sum;
    logic                   hit;
    logic [CNT_W-1:0]       stored_cnt;
    logic [IDX_W-1:0]       wr_inc;
    logic [IDX_W-1:0]       old_inc;
    out_item_t              result;

    resol_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_handle = ram_rdata[WORD_W-1 -: HANDLE_BITS];
    assign rd_size   = ram_rdata[SIZE_BITS-1:0];
    assign wr_inc    = slot_inc(write_slot_reg);
    assign old_inc   = slot_inc(oldest_slot_reg);

    // shared adder and compare of the walk
    assign sum = TOTAL_W'(total_reg + TOTAL_W'(rd_size));
    assign hit = CMP_W'(offset_reg) < CMP_W'(sum);

    always_comb
    begin
        if (ring_full_reg)
        begin
            stored_cnt = FULL_CNT;
        end
        else if (write_slot_reg >= oldest_slot_reg)
        begin
            stored_cnt = CNT_W'(write_slot_reg - oldest_slot_reg);
        end
        else
        begin
            stored_cnt = FULL_CNT - CNT_W'(oldest_slot_reg) + CNT_W'(write_slot_reg);
        end
    end

    always_comb
    begin
        result = '0;
        if (op_reg == OP_ADD)
        begin
            result.evicted_valid = flag_reg;
            if (flag_reg)
            begin
                result.evicted_handle = HANDLE_W'(rd_handle);
            end
        end
        else
        begin
            result.found = flag_reg;
            if (flag_reg)
            begin
                result.hit_handle  = HANDLE_W'(rd_handle);
                result.hit_size    = SIZE_W'(rd_size);
                result.byte_within = BYTE_W'(CMP_W'(offset_reg) - CMP_W'(total_reg));
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        ring_full_next   = ring_full_reg;
        walk_slot_next   = walk_slot_reg;
        chk_valid_next   = chk_valid_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        op_next          = op_reg;
        handle_next      = handle_reg;
        size_next        = size_reg;
        offset_next      = offset_reg;
        issue_idx_next   = issue_idx_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        flag_next        = flag_reg;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = write_slot_reg;
        ram_raddr        = walk_slot_reg;
        ram_wdata        = {handle_reg, size_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.data.operation;
                    handle_next    = HANDLE_BITS'(req.data.entry_handle);
                    size_next      = SIZE_BITS'(req.data.entry_bytes);
                    offset_next    = req.data.seek_offset;
                    issue_idx_next = '0;
                    count_next     = stored_cnt;
                    total_next     = '0;
                    chk_valid_next = 1'b0;
                    walk_slot_next = oldest_slot_reg;
                    state_next     = (req.data.operation == OP_ADD) ? ST_ADD : ST_WALK;
                end
            end
            ST_ADD:
            begin
                // write the new entry and read the one it replaces
                ram_we          = 1'b1;
                ram_re          = 1'b1;
                ram_raddr       = write_slot_reg;
                flag_next       = ring_full_reg;
                write_slot_next = wr_inc;
                if (ring_full_reg)
                begin
                    oldest_slot_next = old_inc;
                end
                ring_full_next = (wr_inc == (ring_full_reg ? old_inc : oldest_slot_reg));
                state_next     = ST_EMIT;
            end
            ST_WALK:
            begin
                if (chk_valid_reg && hit)
                begin
                    flag_next      = 1'b1;
                    chk_valid_next = 1'b0;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    if (chk_valid_reg)
                    begin
                        total_next = sum;
                    end
                    if (issue_idx_reg != count_reg)
                    begin
                        ram_re         = 1'b1;
                        walk_slot_next = slot_inc(walk_slot_reg);
                        issue_idx_next = issue_idx_reg + 1'b1;
                        chk_valid_next = 1'b1;
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                        if (!chk_valid_reg)
                        begin
                            flag_next  = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_data_next  = result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            oldest_slot_reg <= '0;
            ring_full_reg   <= 1'b0;
            walk_slot_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            oldest_slot_reg <= oldest_slot_next;
            ring_full_reg   <= ring_full_next;
            walk_slot_reg   <= walk_slot_next;
            chk_valid_reg   <= chk_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        handle_reg    <= handle_next;
        size_reg      <= size_next;
        offset_reg    <= offset_next;
        issue_idx_reg <= issue_idx_next;
        count_reg     <= count_next;
        total_reg     <= total_next;
        flag_reg      <= flag_next;
        out_data_reg  <= out_data_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    a_full_slots_meet: assert property (@(posedge clk) disable iff (!rst_n)
        ring_full_reg |-> (write_slot_reg == oldest_slot_reg))
        else $error("ring full but slots differ");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (issue_idx_reg <= count_reg))
        else $error("walk issued past stored count");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(write_slot_reg) < DEPTH) && (32'(oldest_slot_reg) < DEPTH))
        else $error("slot pointer out of range");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.found && rsp.data.evicted_valid))
        else $error("result marks both find and add");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item left sequencer idle");
endmodule
